[rtl/core/brg_pkg.sv]
// Bearing angle package: fixed angle formats, the arctangent step table and
// the quadrant flags carried down the pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brg_pkg;

    // Angles are degrees with ANG_Q fraction bits.
    localparam int ANG_Q     = 24;
    localparam int TABLE_LEN = 24;
    localparam int ZW        = 33;
    localparam int VW        = 34;
    localparam int BEARING_W = 15;

    typedef logic signed [ZW-1:0] brg_angle_t;
    typedef logic signed [VW-1:0] brg_value_t;

    // Quadrant information, worked out once and carried with the item.
    typedef struct packed {
        logic dx_neg;
        logic dy_pos;
        logic ax_zero;
    } brg_quad_t;

    localparam brg_angle_t DEG90  = 33'sd1509949440;
    localparam brg_value_t DEG90V = 34'sd1509949440;
    localparam brg_value_t DEG180 = 34'sd3019898880;

    // arctan(2^-i) in degrees, scaled by 2^24.
    localparam brg_angle_t ATAN_STEP [TABLE_LEN] = '{
        33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
        33'sd60000934,  33'sd30029717,  33'sd15018523,  33'sd7509720,
        33'sd3754917,   33'sd1877466,   33'sd938734,    33'sd469367,
        33'sd234684,    33'sd117342,    33'sd58671,     33'sd29335,
        33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
        33'sd917,       33'sd458,       33'sd229,       33'sd115
    };

endpackage

`default_nettype wire

[rtl/core/brg_cordic_stage.sv]
// One registered CORDIC vectoring micro-rotation for the bearing pipeline.
// Depends on brg_pkg for the angle type, the step table and the quadrant flags.
`timescale 1ns / 1ps
`default_nettype none

module brg_cordic_stage #(
    parameter int XW  = 34,
    parameter int IDX = 0
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    vld_in,
    input  wire logic signed [XW-1:0]    x_in,
    input  wire logic signed [XW-1:0]    y_in,
    input  wire brg_pkg::brg_angle_t     z_in,
    input  wire brg_pkg::brg_quad_t      quad_in,
    output logic                         vld_out,
    output logic signed [XW-1:0]         x_out,
    output logic signed [XW-1:0]         y_out,
    output brg_pkg::brg_angle_t          z_out,
    output brg_pkg::brg_quad_t           quad_out
);

    logic                   vld_reg;
    logic signed [XW-1:0]   x_reg;
    logic signed [XW-1:0]   y_reg;
    brg_pkg::brg_angle_t    z_reg;
    brg_pkg::brg_quad_t     quad_reg;

    logic signed [XW-1:0]   x_next;
    logic signed [XW-1:0]   y_next;
    brg_pkg::brg_angle_t    z_next;
    logic signed [XW-1:0]   sx;
    logic signed [XW-1:0]   sy;

    // Rotate towards the x axis; the sign of y picks the direction.
    always_comb
    begin
        sx = x_in >>> IDX;
        sy = y_in >>> IDX;
        if (!y_in[XW-1])
        begin
            x_next = x_in + sy;
            y_next = y_in - sx;
            z_next = z_in + brg_pkg::ATAN_STEP[IDX];
        end
        else
        begin
            x_next = x_in - sy;
            y_next = y_in + sx;
            z_next = z_in - brg_pkg::ATAN_STEP[IDX];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_in)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            quad_reg <= quad_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign quad_out = quad_reg;

endmodule

`default_nettype wire

[rtl/core/bearing_angle_degrees.sv]
// Bearing angle top level: difference, absolute value, CORDIC chain, clamp,
// quadrant rules and rounding. Depends on brg_pkg and brg_cordic_stage.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The input channel carries an item of four coordinates: origin_x, origin_y,
// target_x and target_y, screen style with y growing downward. An item is
// taken at a rising edge where in_valid is high and in_stall is low. The
// output channel returns one bearing per item, in 1/2^ANGLE_FRACTION_BITS
// degree, clockwise from straight up, in the range -180 to 180 degrees.
// Throughput is one item per clock while out_stall is low. An item passes
// through registered stages in order: the difference, the absolute value,
// a stage for each CORDIC micro-rotation, then the clamp, the quadrant rule
// and the rounding into the output register.
// Every stage has its own valid bit. When the receiver holds out_stall, the
// result sits in the output register and the items behind it close up into
// any empty stages; in_stall rises only once every stage holds an item.
// Reset clears all valid bits, so the pipeline starts empty and out_valid is
// low; the data registers are not reset. There is no state between items.
module bearing_angle_degrees #(
    parameter int CORDIC_STAGES       = 16,
    parameter int ANGLE_FRACTION_BITS = 6,
    parameter int COORD_WIDTH         = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] origin_x,
    input  wire logic signed [COORD_WIDTH-1:0] origin_y,
    input  wire logic signed [COORD_WIDTH-1:0] target_x,
    input  wire logic signed [COORD_WIDTH-1:0] target_y,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [brg_pkg::BEARING_W-1:0] bearing
);

    // Stages beyond the step table are not run.
    localparam int NSTG = (CORDIC_STAGES < brg_pkg::TABLE_LEN) ?
                          CORDIC_STAGES : brg_pkg::TABLE_LEN;
    // The magnitudes are lifted to just below bit 60 of a 64-bit word, so the
    // bits lost in each shift sit far below those that steer the rotations.
    localparam int PRE  = 60 - COORD_WIDTH;
    localparam int XW   = 64;
    localparam int SH   = brg_pkg::ANG_Q - ANGLE_FRACTION_BITS;

    // Stage positions along the valid vector.
    localparam int IA = 0;
    localparam int IB = 1;
    localparam int IC = NSTG + 2;
    localparam int ID = NSTG + 3;
    localparam int IE = NSTG + 4;
    localparam int NS = NSTG + 5;

    localparam brg_pkg::brg_value_t HALF = brg_pkg::brg_value_t'(1) <<< (SH - 1);

    logic [NS-1:0] vld;
    logic [NS-1:0] en;

    // A stage may move when there is a gap at or after it, or when the
    // output is being drained this cycle.
    for (genvar k = 0; k < NS; k++)
    begin : g_en
        assign en[k] = !out_stall || !(&vld[NS-1:k]);
    end

    // Stage A: coordinate differences.
    logic                          a_vld_reg;
    logic signed [COORD_WIDTH:0]   dx_reg;
    logic signed [COORD_WIDTH:0]   dy_reg;
    logic signed [COORD_WIDTH:0]   dx_next;
    logic signed [COORD_WIDTH:0]   dy_next;

    assign dx_next = (COORD_WIDTH+1)'(target_x) - (COORD_WIDTH+1)'(origin_x);
    assign dy_next = (COORD_WIDTH+1)'(target_y) - (COORD_WIDTH+1)'(origin_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en[IA])
        begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[IA] && in_valid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // Stage B: magnitudes, quadrant flags and the scaled starting vector.
    logic                          b_vld_reg;
    logic signed [XW-1:0]          x0_reg;
    logic signed [XW-1:0]          y0_reg;
    brg_pkg::brg_quad_t            b_quad_reg;
    logic signed [COORD_WIDTH:0]   ax_full;
    logic signed [COORD_WIDTH:0]   ay_full;
    logic signed [XW-1:0]          x0_next;
    logic signed [XW-1:0]          y0_next;
    brg_pkg::brg_quad_t            b_quad_next;

    always_comb
    begin
        ax_full = dx_reg[COORD_WIDTH] ? -dx_reg : dx_reg;
        ay_full = dy_reg[COORD_WIDTH] ? -dy_reg : dy_reg;
        x0_next = {{(XW-COORD_WIDTH-PRE){1'b0}}, ax_full[COORD_WIDTH-1:0], {PRE{1'b0}}};
        y0_next = {{(XW-COORD_WIDTH-PRE){1'b0}}, ay_full[COORD_WIDTH-1:0], {PRE{1'b0}}};
        b_quad_next.dx_neg  = dx_reg[COORD_WIDTH];
        b_quad_next.dy_pos  = !dy_reg[COORD_WIDTH] && (dy_reg != '0);
        b_quad_next.ax_zero = (dx_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (en[IB])
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[IB] && a_vld_reg)
        begin
            x0_reg     <= x0_next;
            y0_reg     <= y0_next;
            b_quad_reg <= b_quad_next;
        end
    end

    // CORDIC chain, one micro-rotation per stage.
    logic                   c_vld  [NSTG+1];
    logic signed [XW-1:0]   c_x    [NSTG+1];
    logic signed [XW-1:0]   c_y    [NSTG+1];
    brg_pkg::brg_angle_t    c_z    [NSTG+1];
    brg_pkg::brg_quad_t     c_quad [NSTG+1];

    assign c_vld[0]  = b_vld_reg;
    assign c_x[0]    = x0_reg;
    assign c_y[0]    = y0_reg;
    assign c_z[0]    = '0;
    assign c_quad[0] = b_quad_reg;

    for (genvar k = 0; k < NSTG; k++)
    begin : g_cordic
        brg_cordic_stage #(
            .XW  (XW),
            .IDX (k)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en[IB+1+k]),
            .vld_in   (c_vld[k]),
            .x_in     (c_x[k]),
            .y_in     (c_y[k]),
            .z_in     (c_z[k]),
            .quad_in  (c_quad[k]),
            .vld_out  (c_vld[k+1]),
            .x_out    (c_x[k+1]),
            .y_out    (c_y[k+1]),
            .z_out    (c_z[k+1]),
            .quad_out (c_quad[k+1])
        );
        assign vld[IB+1+k] = c_vld[k+1];
    end

    // Stage C: the residual error of the rotations can push the angle just
    // outside 0 to 90 degrees, so it is clamped back into that range.
    logic                   cl_vld_reg;
    brg_pkg::brg_angle_t    a_reg;
    brg_pkg::brg_quad_t     cl_quad_reg;
    brg_pkg::brg_angle_t    a_next;

    always_comb
    begin
        if (c_z[NSTG][brg_pkg::ZW-1])
        begin
            a_next = '0;
        end
        else if (c_z[NSTG] > brg_pkg::DEG90)
        begin
            a_next = brg_pkg::DEG90;
        end
        else
        begin
            a_next = c_z[NSTG];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_vld_reg <= 1'b0;
        end
        else if (en[IC])
        begin
            cl_vld_reg <= c_vld[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[IC] && c_vld[NSTG])
        begin
            a_reg       <= a_next;
            cl_quad_reg <= c_quad[NSTG];
        end
    end

    // Stage D: quadrant rules. A vertical vector gives 0 upward and 180
    // downward; same point counts as upward.
    logic                   q_vld_reg;
    brg_pkg::brg_value_t    v_reg;
    brg_pkg::brg_value_t    v_next;
    brg_pkg::brg_value_t    a_wide;

    always_comb
    begin
        a_wide = brg_pkg::brg_value_t'(a_reg);
        unique case ({cl_quad_reg.dx_neg, cl_quad_reg.dy_pos})
            2'b00:
            begin
                v_next = cl_quad_reg.ax_zero ? '0 : brg_pkg::DEG90V - a_wide;
            end
            2'b10:
            begin
                v_next = a_wide - brg_pkg::DEG90V;
            end
            2'b11:
            begin
                v_next = -a_wide - brg_pkg::DEG90V;
            end
            2'b01:
            begin
                v_next = cl_quad_reg.ax_zero ? brg_pkg::DEG180 : a_wide + brg_pkg::DEG90V;
            end
            default:
            begin
                v_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg <= 1'b0;
        end
        else if (en[ID])
        begin
            q_vld_reg <= cl_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ID] && cl_vld_reg)
        begin
            v_reg <= v_next;
        end
    end

    // Stage E: round to nearest, ties upward, into the output register.
    logic                                 o_vld_reg;
    logic signed [brg_pkg::BEARING_W-1:0] bearing_reg;
    logic signed [brg_pkg::BEARING_W-1:0] bearing_next;
    brg_pkg::brg_value_t                  rounded;

    always_comb
    begin
        rounded      = (v_reg + HALF) >>> SH;
        bearing_next = rounded[brg_pkg::BEARING_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (en[IE])
        begin
            o_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[IE] && q_vld_reg)
        begin
            bearing_reg <= bearing_next;
        end
    end

    assign vld[IA] = a_vld_reg;
    assign vld[IB] = b_vld_reg;
    assign vld[IC] = cl_vld_reg;
    assign vld[ID] = q_vld_reg;
    assign vld[IE] = o_vld_reg;

    assign in_stall  = !en[IA];
    assign out_valid = o_vld_reg;
    assign bearing   = bearing_reg;

    // The input is only held off when every stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld))
        else $error("input stalled while the pipeline has a gap");

    // The clamped angle always lies within 0 to 90 degrees.
    assert property (@(posedge clk) disable iff (!rst_n)
        cl_vld_reg |-> (!a_reg[brg_pkg::ZW-1] && (a_reg <= brg_pkg::DEG90)))
        else $error("clamped angle outside 0 to 90 degrees");

    // Straight up, or the same point, gives exactly zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cl_vld_reg && en[ID] && cl_quad_reg.ax_zero && !cl_quad_reg.dy_pos)
        |=> (v_reg == '0))
        else $error("vertical upward vector did not give zero");

    // Straight down gives exactly 180 degrees.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cl_vld_reg && en[ID] && cl_quad_reg.ax_zero && cl_quad_reg.dy_pos)
        |=> (v_reg == brg_pkg::DEG180))
        else $error("vertical downward vector did not give 180 degrees");

endmodule

`default_nettype wire
